// ===== hw/rtl/trm_pkg.sv =====
`timescale 1ns / 1ps

package trm_pkg;

    localparam int COORD_BITS = 12;
    localparam int SUM_BITS   = 2 * COORD_BITS;
    localparam int LEN_BITS   = COORD_BITS + 1;
    localparam int STEP_BITS  = $clog2(COORD_BITS);

    localparam logic [LEN_BITS-1:0] RUN_CAP = {1'b1, {COORD_BITS{1'b0}}};

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t column;
        coord_t row;
        logic   final_point;
    } point_t;

    typedef struct packed {
        coord_t out_column;
        coord_t out_row;
        logic   end_of_trace;
    } result_t;

    // One output point to be produced: column sum and point count of a run.
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [LEN_BITS-1:0] len;
        coord_t              row;
        logic                last;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIVIDE,
        BK_HOLD
    } back_state_t;

endpackage

// ===== hw/rtl/trm_front.sv =====
`timescale 1ns / 1ps

module trm_front
    import trm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   point_valid,
    output logic   point_stall,
    input  point_t point,
    output logic   cmd_valid,
    input  logic   cmd_stall,
    output cmd_t   cmd
);

    logic                seen_first_reg, seen_first_next;
    logic                run_active_reg, run_active_next;
    coord_t              run_row_reg, run_row_next;
    logic [SUM_BITS-1:0] run_sum_reg, run_sum_next;
    logic [LEN_BITS-1:0] run_len_reg, run_len_next;

    logic slot0_valid_reg, slot0_valid_next;
    logic slot1_valid_reg, slot1_valid_next;
    cmd_t slot0_reg, slot0_next;
    cmd_t slot1_reg, slot1_next;

    logic                push;
    logic                accept;
    logic                same_row;
    logic [SUM_BITS-1:0] col_ext;
    logic [SUM_BITS-1:0] sum_new;
    logic [LEN_BITS-1:0] len_new;
    coord_t              row_new;
    logic                has_first;
    logic                has_second;
    cmd_t                first_cmd;
    cmd_t                second_cmd;

    assign push        = slot0_valid_reg && !cmd_stall;
    assign point_stall = slot1_valid_reg || (slot0_valid_reg && cmd_stall);
    assign accept      = point_valid && !point_stall;
    assign cmd_valid   = slot0_valid_reg;
    assign cmd         = slot0_reg;

    assign same_row = run_active_reg && (point.row == run_row_reg);
    assign col_ext  = {{(SUM_BITS - COORD_BITS){1'b0}}, point.column};

    always_comb
    begin
        if (same_row)
        begin
            row_new = run_row_reg;
            if (run_len_reg != RUN_CAP)
            begin
                sum_new = run_sum_reg + col_ext;
                len_new = run_len_reg + LEN_BITS'(1);
            end
            else
            begin
                sum_new = run_sum_reg;
                len_new = run_len_reg;
            end
        end
        else
        begin
            row_new = point.row;
            sum_new = col_ext;
            len_new = LEN_BITS'(1);
        end
    end

    always_comb
    begin
        has_first  = 1'b0;
        has_second = 1'b0;
        first_cmd  = '{sum: col_ext, len: LEN_BITS'(1), row: point.row,
                       last: point.final_point};
        second_cmd = '{sum: col_ext, len: LEN_BITS'(1), row: point.row, last: 1'b1};
        priority if (!seen_first_reg)
        begin
            has_first = 1'b1;
        end
        else if (run_active_reg && !same_row)
        begin
            has_first  = 1'b1;
            first_cmd  = '{sum: run_sum_reg, len: run_len_reg, row: run_row_reg,
                           last: 1'b0};
            has_second = point.final_point;
            second_cmd = '{sum: sum_new, len: len_new, row: row_new, last: 1'b1};
        end
        else if (point.final_point)
        begin
            has_first  = 1'b1;
            first_cmd  = '{sum: sum_new, len: len_new, row: row_new,
                           last: (len_new == LEN_BITS'(1))};
            has_second = (len_new != LEN_BITS'(1));
        end
    end

    always_comb
    begin
        seen_first_next = seen_first_reg;
        run_active_next = run_active_reg;
        run_row_next    = run_row_reg;
        run_sum_next    = run_sum_reg;
        run_len_next    = run_len_reg;
        if (accept)
        begin
            priority if (!seen_first_reg)
            begin
                seen_first_next = !point.final_point;
            end
            else if (point.final_point)
            begin
                seen_first_next = 1'b0;
                run_active_next = 1'b0;
                run_row_next    = '0;
                run_sum_next    = '0;
                run_len_next    = '0;
            end
            else
            begin
                run_active_next = 1'b1;
                run_row_next    = row_new;
                run_sum_next    = sum_new;
                run_len_next    = len_new;
            end
        end
    end

    always_comb
    begin
        slot0_valid_next = slot0_valid_reg;
        slot1_valid_next = slot1_valid_reg;
        slot0_next       = slot0_reg;
        slot1_next       = slot1_reg;
        if (push)
        begin
            slot0_valid_next = slot1_valid_reg;
            slot0_next       = slot1_reg;
            slot1_valid_next = 1'b0;
        end
        if (accept)
        begin
            slot0_valid_next = has_first;
            slot0_next       = first_cmd;
            slot1_valid_next = has_second;
            slot1_next       = second_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_first_reg  <= 1'b0;
            run_active_reg  <= 1'b0;
            run_row_reg     <= '0;
            run_sum_reg     <= '0;
            run_len_reg     <= '0;
            slot0_valid_reg <= 1'b0;
            slot1_valid_reg <= 1'b0;
        end
        else
        begin
            seen_first_reg  <= seen_first_next;
            run_active_reg  <= run_active_next;
            run_row_reg     <= run_row_next;
            run_sum_reg     <= run_sum_next;
            run_len_reg     <= run_len_next;
            slot0_valid_reg <= slot0_valid_next;
            slot1_valid_reg <= slot1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ===== hw/rtl/trm_queue.sv =====
`timescale 1ns / 1ps

module trm_queue
    import trm_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_stall,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    input  logic rd_stall,
    output cmd_t rd_cmd
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    cmd_t                mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    logic do_wr;
    logic do_rd;

    assign wr_stall = (count_reg == CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !wr_stall;
    assign do_rd    = rd_valid && !rd_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_BITS'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_BITS'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== hw/rtl/trm_back.sv =====
`timescale 1ns / 1ps

module trm_back
    import trm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_stall,
    input  cmd_t    cmd,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    back_state_t          state_reg, state_next;
    logic [SUM_BITS-1:0]  rem_reg;
    logic [SUM_BITS-1:0]  den_reg;
    coord_t               quo_reg;
    logic [STEP_BITS-1:0] step_reg;
    coord_t               row_reg;
    logic                 last_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg;

    logic                take;
    logic                step_en;
    logic                load_out;
    logic                out_free;
    logic                ge;
    logic [SUM_BITS-1:0] rem_sub;

    assign out_free     = !out_valid_reg || !result_stall;
    assign ge           = (rem_reg >= den_reg);
    assign rem_sub      = rem_reg - den_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE:
            begin
                if (step_reg == '0)
                begin
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        take      = 1'b0;
        step_en   = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                cmd_stall = 1'b0;
                take      = cmd_valid;
            end
            BK_DIVIDE:
            begin
                step_en = 1'b1;
            end
            BK_HOLD:
            begin
                load_out = out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Restoring division: the average fits in COORD_BITS, so as many steps suffice.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rem_reg  <= cmd.sum;
            den_reg  <= {cmd.len, {(COORD_BITS - 1){1'b0}}};
            quo_reg  <= '0;
            step_reg <= STEP_BITS'(COORD_BITS - 1);
            row_reg  <= cmd.row;
            last_reg <= cmd.last;
        end
        else if (step_en)
        begin
            rem_reg  <= ge ? rem_sub : rem_reg;
            den_reg  <= den_reg >> 1;
            quo_reg  <= {quo_reg[COORD_BITS-2:0], ge};
            step_reg <= step_reg - STEP_BITS'(1);
        end
        if (load_out)
        begin
            out_reg <= '{out_column: quo_reg, out_row: row_reg, end_of_trace: last_reg};
        end
    end

endmodule

// ===== hw/rtl/trace_run_merger_top.sv =====
`timescale 1ns / 1ps
// Trace run merger.
// Points enter on the point channel (point_valid, point_stall, point) and
// simplified points leave on the result channel (result_valid,
// result_stall, result); an item moves when valid is high and stall is low.
// The first point of a trace is passed on, each later run of points on one
// row becomes one point at the truncated mean column, and a final run of
// more than one point is followed by the final point itself.
// The front end takes one point per cycle when not stalled and turns it into
// zero, one or two pending outputs; it stalls the input while it holds two,
// or one that the queue does not take. A queue of QUEUE_DEPTH entries feeds
// the back end, whose shared restoring divider takes no new entry until the
// result it works on has been loaded into the result register.
// When result_stall is high the result register holds, the back end waits,
// and the queue and front end fill before point_stall rises.
// Reset clears the run state, the queue and the result valid flag.
module trace_run_merger_top
    import trm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    point_valid,
    output logic    point_stall,
    input  point_t  point,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic fq_valid;
    logic fq_stall;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_stall;
    cmd_t qb_cmd;

    trm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .cmd_valid   (fq_valid),
        .cmd_stall   (fq_stall),
        .cmd         (fq_cmd)
    );

    trm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_stall (fq_stall),
        .wr_cmd   (fq_cmd),
        .rd_valid (qb_valid),
        .rd_stall (qb_stall),
        .rd_cmd   (qb_cmd)
    );

    trm_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (qb_valid),
        .cmd_stall    (qb_stall),
        .cmd          (qb_cmd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== hw/rtl/trm_checker.sv =====
`timescale 1ns / 1ps

module trm_checker
    import trm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    point_valid,
    input logic    point_stall,
    input point_t  point,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    logic seen_point_reg, seen_point_next;

    assign seen_point_next = seen_point_reg || (point_valid && !point_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_point_reg <= 1'b0;
        end
        else
        begin
            seen_point_reg <= seen_point_next;
        end
    end

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed or was dropped");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !result_valid)
        else $error("result valid during reset");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> seen_point_reg)
        else $error("result shown before any point was taken");

    a_point_seen_kept: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall |=> seen_point_reg)
        else $error("accepted point not recorded");

endmodule

bind trace_run_merger_top trm_checker u_trm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point        (point),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
